// ===== rtl/core/lcg48_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg48_pkg: shared constants for the 48-bit congruential generator
// Widths, reset values, word kinds and register indexes of the generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lcg48_pkg;

  localparam int STATE_W = 48;
  localparam int INC_W   = 16;
  localparam int SEED_W  = 32;
  localparam int DRAW_W  = 31;
  localparam int VALUE_W = 63;
  localparam int DIGIT_W = 8;
  localparam int NUM_DIGITS = STATE_W / DIGIT_W;
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  localparam logic [STATE_W-1:0] MULT_DEFAULT = 48'h0005_DEEC_E66D;
  localparam logic [INC_W-1:0]   INC_DEFAULT  = 16'h000B;
  localparam logic [STATE_W-1:0] STATE_RESET  = 48'h1234_ABCD_330E;
  localparam logic [15:0]        SEED_LOW     = 16'h330E;

  localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(NUM_DIGITS - 1);

  // Word kinds carried on the input tuser.
  typedef enum logic [1:0] {
    MODE_SEED   = 2'd0,
    MODE_DRAW31 = 2'd1,
    MODE_DRAW63 = 2'd2
  } mode_e;

  // Configuration register indexes.
  localparam logic REG_MULT = 1'b0;
  localparam logic REG_INC  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/lcg48_random_generator.sv =====
// ----------------------------------------------------------------------------
// lcg48_random_generator: 48-bit linear congruential generator (drand48 kind)
// Digit-serial multiply-add engine with a registered result word.
// ----------------------------------------------------------------------------
// Usage.
// Input words arrive on the s_axis channel: tuser carries the word kind
// (seed, 31-bit draw or 63-bit draw) and tdata the 32-bit seed. A seed word
// loads the state with the seed above the constant 0x330E, restores the
// multiplier and increment to their defaults and produces no result; an
// unused kind is dropped. Draw words produce one result word on m_axis.
// The multiplier and increment registers are written through the cfg port
// (index 0 multiplier, index 1 increment); the user must write them only
// while the block is idle, which the block itself does not enforce. Each
// generator step is a multiply-add done one 8-bit digit of the multiplier
// per cycle. A 31-bit draw runs one step from acceptance and then loads
// its result into the output register; a 63-bit draw chains four steps
// before it does. A seed word leaves the block idle. The next word is
// accepted as soon as the result has moved to the output register, so a
// stalled receiver blocks the engine only when a second result is ready
// while the first still waits. Reset restores the state to 0x1234ABCD330E
// and the registers to their defaults, and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcg48_random_generator
  import lcg48_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input words.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [31:0]         s_axis_tdata,   // [31:0] seed_value
  input  wire logic [1:0]          s_axis_tuser,   // [1:0] mode
  // Result words.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [63:0]              m_axis_tdata,   // [62:0] random_value, [63] zero
  // Configuration writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [STATE_W-1:0]  cfg_data_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]             fsm_q, fsm_d;
  logic [STATE_W-1:0]     mult_q, mult_d;
  logic [INC_W-1:0]       inc_q, inc_d;
  logic [STATE_W-1:0]     state_q, state_d;
  logic                   wide_q, wide_d;
  logic [1:0]             draw_cnt_q, draw_cnt_d;
  logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
  logic [STATE_W-1:0]     sshift_q, sshift_d;
  logic [STATE_W-1:0]     mdig_q, mdig_d;
  logic [STATE_W-1:0]     acc_q, acc_d;
  logic [14:0]            tmp_q, tmp_d;
  logic [VALUE_W-1:0]     word_q, word_d;
  logic                   m_valid_q, m_valid_d;
  logic [VALUE_W-1:0]     m_data_q, m_data_d;

  logic [STATE_W+DIGIT_W-1:0] prod;
  logic [STATE_W-1:0]         acc_next;
  logic [DRAW_W-1:0]          draw;
  logic                       in_acc;
  logic                       cfg_acc;

  assign s_axis_tready = (fsm_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i;

  // One digit of the multiplier against the shifted state; wrap at 48 bits.
  assign prod     = sshift_q * mdig_q[DIGIT_W-1:0];
  assign acc_next = acc_q + prod[STATE_W-1:0];
  assign draw     = acc_next[STATE_W-1:STATE_W-DRAW_W];

  always_comb begin
    fsm_d      = fsm_q;
    mult_d     = mult_q;
    inc_d      = inc_q;
    state_d    = state_q;
    wide_d     = wide_q;
    draw_cnt_d = draw_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    sshift_d   = sshift_q;
    mdig_d     = mdig_q;
    acc_d      = acc_q;
    tmp_d      = tmp_q;
    word_d     = word_q;
    m_valid_d  = m_valid_q;
    m_data_d   = m_data_q;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (cfg_acc) begin
      unique case (cfg_index_i)
        REG_MULT: mult_d = cfg_data_i;
        REG_INC:  inc_d  = cfg_data_i[INC_W-1:0];
        default:  ;
      endcase
    end

    unique case (fsm_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (s_axis_tuser) inside
            MODE_SEED: begin
              state_d = {s_axis_tdata, SEED_LOW};
              mult_d  = MULT_DEFAULT;
              inc_d   = INC_DEFAULT;
            end
            MODE_DRAW31, MODE_DRAW63: begin
              wide_d     = (s_axis_tuser == MODE_DRAW63);
              draw_cnt_d = 2'd0;
              dig_cnt_d  = '0;
              sshift_d   = state_q;
              mdig_d     = mult_q;
              acc_d      = {{(STATE_W-INC_W){1'b0}}, inc_q};
              fsm_d      = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        acc_d     = acc_next;
        sshift_d  = sshift_q << DIGIT_W;
        mdig_d    = mdig_q >> DIGIT_W;
        dig_cnt_d = dig_cnt_q + 1'b1;
        if (dig_cnt_q == DIG_LAST) begin
          state_d = acc_next;
          // Fold the finished draw into the result word.
          if (!wide_q) begin
            word_d = {{(VALUE_W-DRAW_W){1'b0}}, draw};
          end else begin
            case (draw_cnt_q) inside
              2'd0, 2'd2: tmp_d = draw[14:0];
              2'd1: word_d[VALUE_W-1:32] = {tmp_q ^ draw[30:16], draw[15:0]};
              default: word_d[31:0] = {1'b0, tmp_q ^ draw[30:16], draw[15:0]};
            endcase
          end
          if (wide_q && (draw_cnt_q != 2'd3)) begin
            draw_cnt_d = draw_cnt_q + 1'b1;
            dig_cnt_d  = '0;
            sshift_d   = acc_next;
            mdig_d     = mult_q;
            acc_d      = {{(STATE_W-INC_W){1'b0}}, inc_q};
          end else begin
            fsm_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = word_q;
          fsm_d     = ST_IDLE;
        end
      end
      default: fsm_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= ST_IDLE;
      mult_q     <= MULT_DEFAULT;
      inc_q      <= INC_DEFAULT;
      state_q    <= STATE_RESET;
      wide_q     <= 1'b0;
      draw_cnt_q <= 2'd0;
      dig_cnt_q  <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      fsm_q      <= fsm_d;
      mult_q     <= mult_d;
      inc_q      <= inc_d;
      state_q    <= state_d;
      wide_q     <= wide_d;
      draw_cnt_q <= draw_cnt_d;
      dig_cnt_q  <= dig_cnt_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sshift_q <= sshift_d;
    mdig_q   <= mdig_d;
    acc_q    <= acc_d;
    tmp_q    <= tmp_d;
    word_q   <= word_d;
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};

  // The digit counter never runs past the last digit of a step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_RUN) |-> (dig_cnt_q <= DIG_LAST))
    else $error("digit counter out of range");

  // A single draw never advances the draw counter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_RUN && !wide_q) |-> (draw_cnt_q == 2'd0))
    else $error("draw counter moved on a single draw");

  // The finish state is entered only from the last digit of the last draw.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_RUN && fsm_d == ST_FIN) |->
      (dig_cnt_q == DIG_LAST && (!wide_q || draw_cnt_q == 2'd3)))
    else $error("step finished early");

  // A seed word loads the state and restores the default coefficients.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser == MODE_SEED) |=>
      (state_q == {$past(s_axis_tdata), SEED_LOW} && mult_q == MULT_DEFAULT
       && inc_q == INC_DEFAULT && fsm_q == ST_IDLE))
    else $error("seed word not applied");

endmodule

`default_nettype wire
